// ===== sv/gma_pkg.sv =====
// ----------------------------------------------------------------------------
// gma_pkg: shared types and constants for the gated moving average core
// Payload structs, configuration register indexes and request codes.
// ----------------------------------------------------------------------------
package gma_pkg;

    localparam int MAX_WINDOW_DEFAULT = 32;

    localparam int DATA_W       = 16;
    localparam int REQ_W        = 2;
    localparam int CFG_LEN_W    = 6;
    localparam int CFG_PERIOD_W = 8;
    localparam int CFG_DATA_W   = 8;
    localparam int CFG_IDX_W    = 2;
    localparam int ELAPSED_W    = 9;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 2'd1;

    localparam logic [CFG_LEN_W-1:0]    WINDOW_LENGTH_RESET = 6'd32;
    localparam logic [CFG_PERIOD_W-1:0] SAMPLE_PERIOD_RESET = 8'd0;
    localparam logic [ELAPSED_W-1:0]    ELAPSED_SAT         = 9'd256;

    localparam logic [REQ_W-1:0] REQ_TICK   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SAMPLE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_PRESET = 2'd2;

    typedef struct packed {
        logic [REQ_W-1:0]         req_type;
        logic signed [DATA_W-1:0] value;
    } gma_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] average;
        logic                     accepted;
    } gma_out_t;

endpackage

// ===== sv/gma_store.sv =====
// ----------------------------------------------------------------------------
// gma_store: sample ring storage
// One write port, one registered read port; per-entry valid bits make
// entries that were not written since reset or a clear read as zero.
// ----------------------------------------------------------------------------
module gma_store
    import gma_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEFAULT,
    localparam int SLOT_W    = $clog2(MAX_WINDOW)
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     clear,
    input  logic                     wr_en,
    input  logic [SLOT_W-1:0]        wr_addr,
    input  logic signed [DATA_W-1:0] wr_data,
    input  logic [SLOT_W-1:0]        rd_addr,
    output logic signed [DATA_W-1:0] rd_data
);

    logic signed [DATA_W-1:0] store_mem [MAX_WINDOW];
    logic [MAX_WINDOW-1:0]    valid_reg;
    logic signed [DATA_W-1:0] rd_data_reg;
    logic                     rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= store_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ===== sv/gma_divider.sv =====
// ----------------------------------------------------------------------------
// gma_divider: serial signed-by-unsigned divider
// Restoring division on the magnitude, one quotient bit per cycle,
// quotient truncated toward zero and returned as its low 16 bits.
// ----------------------------------------------------------------------------
module gma_divider
    import gma_pkg::*;
#(
    parameter int SUM_W = 21,
    parameter int LEN_W = 6,
    localparam int DCNT_W = $clog2(SUM_W)
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [SUM_W-1:0]  dividend,
    input  logic [LEN_W-1:0]         divisor,
    output logic                     done,
    output logic signed [DATA_W-1:0] quotient
);

    logic [SUM_W-1:0]  mag_reg,  mag_next;
    logic [LEN_W-1:0]  rem_reg,  rem_next;
    logic [LEN_W-1:0]  den_reg;
    logic [DCNT_W-1:0] cnt_reg,  cnt_next;
    logic              neg_reg;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [LEN_W:0]    trial;
    logic [LEN_W:0]    trial_diff;
    logic [SUM_W-1:0]  signed_q;

    assign trial      = {rem_reg, mag_reg[SUM_W-1]};
    assign trial_diff = trial - {1'b0, den_reg};

    always_comb begin
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (busy_reg) begin
            // quotient bits shift in at the bottom as dividend bits leave the top
            if (!trial_diff[LEN_W]) begin
                rem_next = trial_diff[LEN_W-1:0];
                mag_next = {mag_reg[SUM_W-2:0], 1'b1};
            end else begin
                rem_next = trial[LEN_W-1:0];
                mag_next = {mag_reg[SUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DCNT_W'(SUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            mag_reg <= dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
            rem_reg <= '0;
            den_reg <= divisor;
            cnt_reg <= '0;
            neg_reg <= dividend[SUM_W-1];
        end else begin
            mag_reg <= mag_next;
            rem_reg <= rem_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign signed_q = neg_reg ? (~mag_reg + 1'b1) : mag_reg;
    assign quotient = signed_q[DATA_W-1:0];
    assign done     = done_reg;

endmodule

// ===== sv/gated_moving_average_core.sv =====
// ----------------------------------------------------------------------------
// gated_moving_average_core: gated boxcar moving-average filter
// Ticks, samples and presets in; one average per transaction out.
// ----------------------------------------------------------------------------
// Input transactions arrive on s_valid/s_ready/s_data: a millisecond tick,
// a sample (taken only once more than sample_period_ms ticks have passed)
// or a preset that fills the window with one value. Every input transaction
// yields one result on m_valid/m_ready/m_data: the running sum divided by
// the window length, truncated toward zero, plus a flag for a taken sample.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user
// must write it only while idle, as the block does not enforce this.
// Writing window_length empties the window. A small sequencer around a
// serial divider that produces one quotient bit per cycle handles each
// transaction one at a time: a tick goes from accept through ST_DSTART,
// ST_DWAIT and ST_OUT to m_valid, a taken sample passes ST_UPDATE first
// and a preset ST_FILL for its fill sweep through the single write port
// of the sample store. s_ready is high only while idle.
// A result waiting on a stalled receiver sits in the output register; the
// next transaction is still accepted and holds at its end until the
// output register is free. Synchronous reset empties the window, clears
// the running sum, slot and elapsed count and restores the registers.
// ----------------------------------------------------------------------------
module gated_moving_average_core
    import gma_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEFAULT
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  gma_in_t                 s_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output gma_out_t                m_data,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    localparam int SLOT_W = $clog2(MAX_WINDOW);
    localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W  = DATA_W + $clog2(MAX_WINDOW);
    localparam int CMP_W  = (SLOT_W + 1 > CFG_LEN_W) ? SLOT_W + 1 : CFG_LEN_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_UPDATE = 3'd1;
    localparam logic [2:0] ST_FILL   = 3'd2;
    localparam logic [2:0] ST_DSTART = 3'd3;
    localparam logic [2:0] ST_DWAIT  = 3'd4;
    localparam logic [2:0] ST_OUT    = 3'd5;

    logic [2:0]               state_reg, state_next;
    logic [CFG_LEN_W-1:0]     window_length_reg;
    logic [CFG_PERIOD_W-1:0]  sample_period_reg;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic [SLOT_W-1:0]        slot_reg, slot_next;
    logic [ELAPSED_W-1:0]     elapsed_reg, elapsed_next;
    logic [SLOT_W-1:0]        work_slot_reg, work_slot_next;
    logic signed [DATA_W-1:0] value_reg, value_next;
    logic                     acc_reg, acc_next;
    logic                     m_valid_reg, m_valid_next;
    gma_out_t                 m_data_reg, m_data_next;

    logic [CMP_W-1:0]         wl_ext;
    logic [CMP_W-1:0]         len_cmp;
    logic [LEN_W-1:0]         len;
    logic [SLOT_W-1:0]        slot_start;
    logic [CMP_W-1:0]         slot_inc;
    logic                     in_fire;
    logic                     len_write;

    logic                     st_wr_en;
    logic [SLOT_W-1:0]        st_wr_addr;
    logic signed [DATA_W-1:0] st_rd_data;
    logic signed [SUM_W-1:0]  value_ext;
    logic signed [SUM_W-1:0]  old_ext;

    logic                     div_start;
    logic                     div_done;
    logic signed [DATA_W-1:0] div_quotient;

    // effective length: zero counts as one, clamped to the depth
    assign wl_ext  = CMP_W'(window_length_reg);
    assign len_cmp = (wl_ext == '0) ? CMP_W'(1) :
                     (wl_ext > CMP_W'(MAX_WINDOW)) ? CMP_W'(MAX_WINDOW) : wl_ext;
    assign len     = LEN_W'(len_cmp);

    assign slot_start = (CMP_W'(slot_reg) >= len_cmp) ? '0 : slot_reg;
    assign slot_inc   = CMP_W'(work_slot_reg) + CMP_W'(1);

    assign in_fire   = s_valid && s_ready;
    assign len_write = cfg_we && (cfg_index == REG_WINDOW_LENGTH);

    assign value_ext = SUM_W'(value_reg);
    assign old_ext   = SUM_W'(st_rd_data);

    assign st_wr_en   = (state_reg == ST_UPDATE) || (state_reg == ST_FILL);
    assign st_wr_addr = work_slot_reg;
    assign div_start  = (state_reg == ST_DSTART);

    gma_store #(
        .MAX_WINDOW(MAX_WINDOW)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (len_write),
        .wr_en   (st_wr_en),
        .wr_addr (st_wr_addr),
        .wr_data (value_reg),
        .rd_addr (slot_start),
        .rd_data (st_rd_data)
    );

    gma_divider #(
        .SUM_W(SUM_W),
        .LEN_W(LEN_W)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (len),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb begin
        state_next     = state_reg;
        sum_next       = sum_reg;
        slot_next      = slot_reg;
        elapsed_next   = elapsed_reg;
        work_slot_next = work_slot_reg;
        value_next     = value_reg;
        acc_next       = acc_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    value_next = s_data.value;
                    acc_next   = 1'b0;
                    state_next = ST_DSTART;
                    case (s_data.req_type)
                        REQ_TICK: begin
                            if (elapsed_reg < ELAPSED_SAT) begin
                                elapsed_next = elapsed_reg + 1'b1;
                            end
                        end
                        REQ_SAMPLE: begin
                            if (elapsed_reg > ELAPSED_W'(sample_period_reg)) begin
                                work_slot_next = slot_start;
                                state_next     = ST_UPDATE;
                            end
                        end
                        REQ_PRESET: begin
                            work_slot_next = '0;
                            sum_next       = '0;
                            state_next     = ST_FILL;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_UPDATE: begin
                // old entry read back at the accept edge
                sum_next     = sum_reg + value_ext - old_ext;
                slot_next    = (slot_inc >= len_cmp) ? '0 : SLOT_W'(slot_inc);
                elapsed_next = '0;
                acc_next     = 1'b1;
                state_next   = ST_DSTART;
            end
            ST_FILL: begin
                sum_next       = sum_reg + value_ext;
                work_slot_next = SLOT_W'(slot_inc);
                if (CMP_W'(work_slot_reg) == len_cmp - CMP_W'(1)) begin
                    state_next = ST_DSTART;
                end
            end
            ST_DSTART: begin
                state_next = ST_DWAIT;
            end
            ST_DWAIT: begin
                if (div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next         = 1'b1;
                    m_data_next.average  = div_quotient;
                    m_data_next.accepted = acc_reg;
                    state_next           = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // a length write empties the window; the user must issue it only while idle, the block does not check
        if (len_write) begin
            sum_next  = '0;
            slot_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            window_length_reg <= WINDOW_LENGTH_RESET;
            sample_period_reg <= SAMPLE_PERIOD_RESET;
            sum_reg           <= '0;
            slot_reg          <= '0;
            elapsed_reg       <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sum_reg     <= sum_next;
            slot_reg    <= slot_next;
            elapsed_reg <= elapsed_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                case (cfg_index)
                    REG_WINDOW_LENGTH: window_length_reg <= cfg_data[CFG_LEN_W-1:0];
                    REG_SAMPLE_PERIOD: sample_period_reg <= cfg_data[CFG_PERIOD_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        work_slot_reg <= work_slot_next;
        value_reg     <= value_next;
        acc_reg       <= acc_next;
        m_data_reg    <= m_data_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== bench/average_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// average_checker: scoreboard for the gated moving average core
// Watches the config port and both channels, keeps its own copy of the
// window, running sum, write slot and elapsed count, predicts one result per
// input transaction and compares each output transaction against it.
// ----------------------------------------------------------------------------
module average_checker
    import gma_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  gma_in_t               s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  gma_out_t              m_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatch_count,
    output int                    results_seen
);

    logic [CFG_LEN_W-1:0]     window_length;
    logic [CFG_PERIOD_W-1:0]  sample_period;
    logic signed [DATA_W-1:0] taps [MAX_WINDOW];
    longint                   running_sum;
    int                       write_slot;
    int                       elapsed_ms;
    gma_out_t                 expected_averages [$];

    function automatic int effective_length();
        if (window_length == 0) return 1;
        if (window_length > MAX_WINDOW) return MAX_WINDOW;
        return int'(window_length);
    endfunction

    task automatic clear_window();
        for (int i = 0; i < MAX_WINDOW; i++) taps[i] = '0;
        running_sum = 0;
        write_slot = 0;
    endtask

    // updates the filter state for one transaction and returns its result
    function automatic gma_out_t filter_step(gma_in_t item);
        gma_out_t result;
        int len;
        int slot;
        len = effective_length();
        result.accepted = 1'b0;
        case (item.req_type)
            REQ_TICK: begin
                if (elapsed_ms < int'(ELAPSED_SAT)) elapsed_ms++;
            end
            REQ_SAMPLE: begin
                if (elapsed_ms > int'(sample_period)) begin
                    slot = (write_slot >= len) ? 0 : write_slot;
                    running_sum += longint'(item.value) - longint'(taps[slot]);
                    taps[slot] = item.value;
                    slot++;
                    write_slot = (slot >= len) ? 0 : slot;
                    elapsed_ms = 0;
                    result.accepted = 1'b1;
                end
            end
            REQ_PRESET: begin
                for (int i = 0; i < len; i++) taps[i] = item.value;
                running_sum = longint'(item.value) * len;
            end
            default: ;
        endcase
        // signed longint division truncates toward zero
        result.average = DATA_W'(running_sum / len);
        return result;
    endfunction

    always @(posedge aclk) begin
        gma_out_t want;
        if (!aresetn) begin
            window_length = WINDOW_LENGTH_RESET;
            sample_period = SAMPLE_PERIOD_RESET;
            clear_window();
            elapsed_ms = 0;
            expected_averages.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_WINDOW_LENGTH) begin
                    window_length = cfg_data[CFG_LEN_W-1:0];
                    clear_window();
                end else if (cfg_index == REG_SAMPLE_PERIOD) begin
                    sample_period = cfg_data[CFG_PERIOD_W-1:0];
                end
            end
            if (m_valid && m_ready) begin
                results_seen <= results_seen + 1;
                if (expected_averages.size() == 0) begin
                    $display("%0t: unexpected result transaction: expected none, actual %0d/%0b",
                             $time, m_data.average, m_data.accepted);
                    mismatch_count++;
                end else begin
                    want = expected_averages.pop_front();
                    if (m_data.average !== want.average) begin
                        $display("%0t: average mismatch: expected %0d, actual %0d",
                                 $time, want.average, m_data.average);
                        mismatch_count++;
                    end
                    if (m_data.accepted !== want.accepted) begin
                        $display("%0t: accepted mismatch: expected %0b, actual %0b",
                                 $time, want.accepted, m_data.accepted);
                        mismatch_count++;
                    end
                end
            end
            if (s_valid && s_ready) expected_averages.push_back(filter_step(s_data));
        end
    end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the gated moving average core
// Directed ticks, samples and presets at the field extremes, a long tick run
// against the largest sample period, then random phases over several window
// lengths and periods with varying idle patterns on both channels.
// ----------------------------------------------------------------------------
module testbench;
    import gma_pkg::*;

    localparam int RANDOM_PER_PHASE = 40;
    localparam int HOLD_OFF_CYCLES  = 400;

    localparam logic [REQ_W-1:0]     REQ_UNUSED      = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 2'd3;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    gma_in_t               s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    gma_out_t              m_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_WINDOW_LENGTH;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int mismatch_count;
    int results_seen;
    int requests_sent    = 0;
    int send_idle_pct    = 0;
    int recv_idle_pct    = 0;
    int recv_hold_cycles = 0;

    gated_moving_average_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    average_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .results_seen   (results_seen)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // receiver: random stalls, or a counted hold-off when one is requested
    always @(posedge aclk) begin
        if (recv_hold_cycles > 0) begin
            m_ready <= 1'b0;
            recv_hold_cycles <= recv_hold_cycles - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_request(logic [REQ_W-1:0] kind, logic [DATA_W-1:0] value);
        gma_in_t req;
        req.req_type = kind;
        req.value = value;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= req;
        do @(posedge aclk); while (!s_ready);
        requests_sent++;
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (results_seen != requests_sent) @(posedge aclk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [DATA_W-1:0] random_value();
        case ($urandom_range(9))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return DATA_W'(int'($urandom_range(15)) - 8);
            default: return DATA_W'($urandom);
        endcase
    endfunction

    // mostly tick runs ending in a sample, with run lengths around the period
    // so that samples are both taken and refused; the rest is noise
    task automatic run_random(int count, int period);
        int sent;
        int burst;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(99) < 80) begin
                burst = $urandom_range(period + 2, (period > 0) ? period - 1 : 0);
                repeat (burst) send_request(REQ_TICK, random_value());
                send_request(REQ_SAMPLE, random_value());
                sent += burst + 1;
            end else begin
                send_request(REQ_W'($urandom_range(3)), random_value());
                sent++;
            end
        end
    endtask

    task automatic run_phase(logic [CFG_DATA_W-1:0] length, logic [CFG_DATA_W-1:0] period,
                             int send_pct, int recv_pct);
        wait_for_results();
        write_register(REG_WINDOW_LENGTH, length);
        write_register(REG_SAMPLE_PERIOD, period);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        run_random(RANDOM_PER_PHASE, int'(period));
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: length 32, period 0
        send_idle_pct = 9;
        recv_idle_pct = 84;
        send_request(REQ_SAMPLE, 16'h7fff);     // refused, nothing elapsed yet
        send_request(REQ_TICK, 16'h0000);
        send_request(REQ_SAMPLE, 16'h7fff);
        send_request(REQ_PRESET, 16'h7fff);
        send_request(REQ_PRESET, 16'h8000);
        send_request(REQ_TICK, 16'hffff);
        send_request(REQ_SAMPLE, 16'h7fff);
        send_request(REQ_UNUSED, 16'hffff);
        send_request(REQ_UNUSED, 16'h0000);
        send_request(REQ_PRESET, 16'hfffd);
        send_request(REQ_TICK, 16'h0000);
        send_request(REQ_SAMPLE, 16'h8000);
        send_request(REQ_TICK, 16'h0000);
        send_request(REQ_SAMPLE, 16'h0001);
        send_request(REQ_SAMPLE, 16'h5555);
        wait_for_results();

        // unmapped indexes must do nothing
        write_register(REG_UNMAPPED_LO, 8'hff);
        write_register(REG_UNMAPPED_HI, 8'hff);

        // length above the depth clamps to 32; longest period with elapsed saturation
        write_register(REG_WINDOW_LENGTH, 8'hff);
        write_register(REG_SAMPLE_PERIOD, 8'hff);
        repeat (260) send_request(REQ_TICK, random_value());
        send_request(REQ_SAMPLE, 16'h7fff);
        repeat (255) send_request(REQ_TICK, random_value());
        send_request(REQ_SAMPLE, 16'h8000);     // refused, elapsed equals period
        send_request(REQ_TICK, 16'h0000);
        send_request(REQ_SAMPLE, 16'h8000);

        run_phase(8'd4, 8'd0, 9, 84);
        run_phase(8'd1, 8'd3, 9, 84);
        run_phase(8'd0, 8'd1, 84, 9);
        run_phase(8'd7, 8'd2, 84, 9);

        // receiver holds off while the sender keeps offering, then a full drain
        wait_for_results();
        write_register(REG_WINDOW_LENGTH, 8'd32);
        write_register(REG_SAMPLE_PERIOD, 8'd0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        recv_hold_cycles = HOLD_OFF_CYCLES;
        run_random(40, 0);
        wait_for_results();
        run_random(RANDOM_PER_PHASE, 0);

        run_phase(8'd2, 8'd5, 0, 0);

        wait_for_results();
        repeat (60) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
